[hw/rtl/crtm_pkg.sv]
package crtm_pkg;

  localparam int MOD_BITS_DEF = 32;
  localparam int ACC_BITS_DEF = 64;

  // port widths of the item and result fields
  localparam int MOD_W  = 32;
  localparam int SOL_W  = 64;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSOL = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_RED, S_BM, S_GCD, S_RM, S_CD, S_T, S_BD, S_A,
    S_EQ, S_EM, S_K, S_KM, S_OV, S_MT, S_MK, S_DONE
  } crt_state_t;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_rsp_t;

endpackage

[hw/rtl/crtm_item_if.sv]
interface crtm_item_if
  import crtm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] modulus;
  logic [MOD_W-1:0] residue;
  logic             last_item;

  modport source (output valid, modulus, residue, last_item, input ready);
  modport sink (input valid, modulus, residue, last_item, output ready);
endinterface

[hw/rtl/crtm_result_if.sv]
interface crtm_result_if
  import crtm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SOL_W-1:0]  solution;
  logic [SOL_W-1:0]  combined_modulus;
  logic [STAT_W-1:0] status;

  modport source (output valid, solution, combined_modulus, status, input ready);
  modport sink (input valid, solution, combined_modulus, status, output ready);
endinterface

[hw/rtl/crt_merge_general_moduli_unit.sv]
// generalized chinese remainder merge over moduli that need not be coprime
// items: one congruence x = residue mod modulus per transaction, last_item closes
// the system; results: one transaction per closed system with the least
// non-negative solution, the lcm and a status (0 solved, 1 none, 2 lcm overflow)
// an item takes a series of divides and multiplies on one shared bit-serial unit;
// a first item takes one divide, a merging item that solves nine divides and three
// multiplies plus one divide per euclid gcd step and one divide and one multiply
// per inverse step; an item after an error skips the unit and goes straight to done
// items.ready is high only while the sequencer is idle
// a result sits in an output register; while it waits the block still takes the
// next items, and only a later closing item holds until the register frees up
// reset (synchronous, active high) empties the output register and returns the
// running modulus to one, the residue to zero and clears the error
module crt_merge_general_moduli_unit
  import crtm_pkg::*;
#(
  parameter int MOD_BITS = MOD_BITS_DEF,
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input logic            clk,
  input logic            rst,
  crtm_item_if.sink      items,
  crtm_result_if.source  results
);

  localparam int MB = MOD_BITS;
  localparam int AB = ACC_BITS;
  localparam int DW = (AB > 2 * MB) ? AB : 2 * MB;
  localparam int SW = MB + 2;
  localparam logic [DW-1:0] ACC_MAX = DW'({AB{1'b1}});

  crt_state_t state, state_next;
  logic issue, issue_next;

  // running system
  logic [AB-1:0]     run_mod, run_mod_next;
  logic [AB-1:0]     run_res, run_res_next;
  logic [STAT_W-1:0] err, err_next;
  logic              awaiting, awaiting_next;

  // current item and working values
  logic [MB-1:0] m, m_next;
  logic [MB-1:0] r, r_next;
  logic          last, last_next;
  logic [MB-1:0] ga, ga_next;
  logic [MB-1:0] gb, gb_next;
  logic [MB-1:0] c, c_next;
  logic [MB-1:0] cq, cq_next;
  logic [MB-1:0] t, t_next;
  logic [DW-1:0] tmp, tmp_next;
  logic [MB-1:0] r0, r0_next;
  logic [MB-1:0] r1, r1_next;
  logic [MB-1:0] q, q_next;
  logic signed [SW-1:0] s0, s0_next;
  logic signed [SW-1:0] s1, s1_next;
  logic [MB-1:0] inv, inv_next;
  logic [MB-1:0] k, k_next;
  logic [AB-1:0] newmod, newmod_next;

  // output register
  logic              out_valid, out_valid_next;
  logic [SOL_W-1:0]  out_sol, out_sol_next;
  logic [SOL_W-1:0]  out_mod, out_mod_next;
  logic [STAT_W-1:0] out_stat, out_stat_next;

  // shared unit
  mdu_cmd_t      cmd;
  mdu_rsp_t      rsp;
  logic [DW-1:0] opa;
  logic [MB:0]   opb;
  logic [DW-1:0] quo;
  logic [DW-1:0] prod;
  logic [MB-1:0] rem;

  crtm_mdu #(.MB(MB), .DW(DW)) u_mdu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .opa  (opa),
    .opb  (opb),
    .rsp  (rsp),
    .quo  (quo),
    .prod (prod),
    .rem  (rem)
  );

  // helpers for the extended euclid update
  logic                 s1neg;
  logic signed [SW-1:0] s1mag;
  logic signed [SW-1:0] pmag;
  logic signed [SW-1:0] tt;
  logic signed [SW-1:0] sfix;
  logic [MB:0]          cdiff;

  assign s1neg = s1[SW-1];
  assign s1mag = s1neg ? -s1 : s1;
  assign pmag  = signed'(prod[SW-1:0]);
  assign tt    = signed'({2'b00, t});
  // final coefficient of the inverse lands in [0, t)
  assign sfix  = (s1 < 0) ? s1 + tt : ((s1 >= tt) ? s1 - tt : s1);
  // residue difference, kept below m
  assign cdiff = (r >= rem) ? {1'b0, r} - {1'b0, rem} : {1'b0, r} + {1'b0, m} - {1'b0, rem};

  // operand select for the unit
  always_comb begin
    cmd.start = issue;
    cmd.op    = OP_DIV;
    opa       = '0;
    opb       = '0;
    unique case (state)
      S_RED: begin opa = DW'(r);       opb = {1'b0, m};  end
      S_BM:  begin opa = DW'(run_mod); opb = {1'b0, m};  end
      S_GCD: begin opa = DW'(ga);      opb = {1'b0, gb}; end
      S_RM:  begin opa = DW'(run_res); opb = {1'b0, m};  end
      S_CD:  begin opa = DW'(c);       opb = {1'b0, ga}; end
      S_T:   begin opa = DW'(m);       opb = {1'b0, ga}; end
      S_BD:  begin opa = DW'(run_mod); opb = {1'b0, ga}; end
      S_A:   begin opa = tmp;          opb = {1'b0, t};  end
      S_EQ:  begin opa = DW'(r0);      opb = {1'b0, r1}; end
      S_EM:  begin cmd.op = OP_MUL; opa = DW'(q);       opb = s1mag[MB:0];    end
      S_K:   begin cmd.op = OP_MUL; opa = DW'(cq);      opb = {1'b0, inv};    end
      S_KM:  begin opa = tmp;          opb = {1'b0, t};  end
      S_OV:  begin opa = ACC_MAX;      opb = {1'b0, t};  end
      S_MT:  begin cmd.op = OP_MUL; opa = DW'(run_mod); opb = {1'b0, t};      end
      S_MK:  begin cmd.op = OP_MUL; opa = DW'(run_mod); opb = {1'b0, k};      end
      default: cmd.start = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_next    = state;
    issue_next    = 1'b0;
    run_mod_next  = run_mod;
    run_res_next  = run_res;
    err_next      = err;
    awaiting_next = awaiting;
    m_next        = m;
    r_next        = r;
    last_next     = last;
    ga_next       = ga;
    gb_next       = gb;
    c_next        = c;
    cq_next       = cq;
    t_next        = t;
    tmp_next      = tmp;
    r0_next       = r0;
    r1_next       = r1;
    q_next        = q;
    s0_next       = s0;
    s1_next       = s1;
    inv_next      = inv;
    k_next        = k;
    newmod_next   = newmod;
    out_valid_next = out_valid && !results.ready;
    out_sol_next  = out_sol;
    out_mod_next  = out_mod;
    out_stat_next = out_stat;
    items.ready   = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (items.valid) begin
          m_next    = items.modulus[MB-1:0];
          r_next    = items.residue[MB-1:0];
          last_next = items.last_item;
          if (err != ST_OK) begin
            state_next = S_DONE;
          end else if (items.modulus[MB-1:0] == '0) begin
            // zero modulus has no solution
            err_next   = ST_NOSOL;
            state_next = S_DONE;
          end else begin
            state_next = S_RED;
            issue_next = 1'b1;
          end
        end
      end
      S_RED: if (rsp.done) begin
        r_next = rem;
        if (awaiting) begin
          if (DW'(m) > ACC_MAX) begin
            err_next = ST_OVF;
          end else begin
            run_mod_next  = AB'(m);
            run_res_next  = AB'(rem);
            awaiting_next = 1'b0;
          end
          state_next = S_DONE;
        end else begin
          state_next = S_BM;
          issue_next = 1'b1;
        end
      end
      S_BM: if (rsp.done) begin
        ga_next    = m;
        gb_next    = rem;
        issue_next = 1'b1;
        state_next = (rem == '0) ? S_RM : S_GCD;
      end
      S_GCD: if (rsp.done) begin
        // ga ends as the gcd
        ga_next    = gb;
        gb_next    = rem;
        issue_next = 1'b1;
        state_next = (rem == '0) ? S_RM : S_GCD;
      end
      S_RM: if (rsp.done) begin
        c_next     = cdiff[MB-1:0];
        state_next = S_CD;
        issue_next = 1'b1;
      end
      S_CD: if (rsp.done) begin
        if (rem != '0) begin
          err_next   = ST_NOSOL;
          state_next = S_DONE;
        end else begin
          cq_next    = quo[MB-1:0];
          state_next = S_T;
          issue_next = 1'b1;
        end
      end
      S_T: if (rsp.done) begin
        t_next     = quo[MB-1:0];
        state_next = S_BD;
        issue_next = 1'b1;
      end
      S_BD: if (rsp.done) begin
        tmp_next   = quo;
        state_next = S_A;
        issue_next = 1'b1;
      end
      S_A: if (rsp.done) begin
        issue_next = 1'b1;
        if (t <= MB'(1)) begin
          inv_next   = '0;
          state_next = S_K;
        end else begin
          r0_next    = rem;
          r1_next    = t;
          s0_next    = SW'(1);
          s1_next    = '0;
          state_next = S_EQ;
        end
      end
      S_EQ: if (rsp.done) begin
        q_next     = quo[MB-1:0];
        r0_next    = r1;
        r1_next    = rem;
        state_next = S_EM;
        issue_next = 1'b1;
      end
      S_EM: if (rsp.done) begin
        s0_next    = s1;
        s1_next    = s1neg ? s0 + pmag : s0 - pmag;
        issue_next = 1'b1;
        if (r1 == '0) begin
          inv_next   = sfix[MB-1:0];
          state_next = S_K;
        end else begin
          state_next = S_EQ;
        end
      end
      S_K: if (rsp.done) begin
        tmp_next   = prod;
        state_next = S_KM;
        issue_next = 1'b1;
      end
      S_KM: if (rsp.done) begin
        k_next     = rem;
        state_next = S_OV;
        issue_next = 1'b1;
      end
      S_OV: if (rsp.done) begin
        if (DW'(run_mod) > quo) begin
          err_next   = ST_OVF;
          state_next = S_DONE;
        end else begin
          state_next = S_MT;
          issue_next = 1'b1;
        end
      end
      S_MT: if (rsp.done) begin
        newmod_next = prod[AB-1:0];
        state_next  = S_MK;
        issue_next  = 1'b1;
      end
      S_MK: if (rsp.done) begin
        run_res_next = run_res + prod[AB-1:0];
        run_mod_next = newmod;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!last) begin
          state_next = S_IDLE;
        end else if (!out_valid || results.ready) begin
          out_valid_next = 1'b1;
          out_stat_next  = err;
          out_sol_next   = (err == ST_OK) ? SOL_W'(run_res) : '0;
          out_mod_next   = (err == ST_OK) ? SOL_W'(run_mod) : '0;
          run_mod_next   = AB'(1);
          run_res_next   = '0;
          err_next       = ST_OK;
          awaiting_next  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue     <= 1'b0;
      run_mod   <= AB'(1);
      run_res   <= '0;
      err       <= ST_OK;
      awaiting  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      issue     <= issue_next;
      run_mod   <= run_mod_next;
      run_res   <= run_res_next;
      err       <= err_next;
      awaiting  <= awaiting_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    m        <= m_next;
    r        <= r_next;
    last     <= last_next;
    ga       <= ga_next;
    gb       <= gb_next;
    c        <= c_next;
    cq       <= cq_next;
    t        <= t_next;
    tmp      <= tmp_next;
    r0       <= r0_next;
    r1       <= r1_next;
    q        <= q_next;
    s0       <= s0_next;
    s1       <= s1_next;
    inv      <= inv_next;
    k        <= k_next;
    newmod   <= newmod_next;
    out_sol  <= out_sol_next;
    out_mod  <= out_mod_next;
    out_stat <= out_stat_next;
  end

  assign results.valid            = out_valid;
  assign results.solution         = out_sol;
  assign results.combined_modulus = out_mod;
  assign results.status           = out_stat;

`ifndef SYNTHESIS
  // a new item never arrives while the shared unit still runs
  a_ready_unit_idle: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> !rsp.busy && !issue)
    else $error("item taken while unit busy");

  // the running residue stays reduced between items
  a_res_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && err == ST_OK && !awaiting) |-> run_res < run_mod)
    else $error("running residue not reduced");

  // before the first congruence the running pair holds its reset value
  a_await_pair: assert property (@(posedge clk) disable iff (rst)
    awaiting |-> (run_mod == AB'(1)) && (run_res == '0))
    else $error("running pair changed before first item");

  // a start always sets the unit busy
  a_done_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> rsp.busy)
    else $error("unit did not start");
`endif

endmodule

[hw/rtl/crtm_mdu.sv]
module crtm_mdu
  import crtm_pkg::*;
#(
  parameter int MB = MOD_BITS_DEF,
  parameter int DW = 2 * MOD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  mdu_cmd_t      cmd,
  input  logic [DW-1:0] opa,
  input  logic [MB:0]   opb,
  output mdu_rsp_t      rsp,
  output logic [DW-1:0] quo,
  output logic [DW-1:0] prod,
  output logic [MB-1:0] rem
);

  localparam int CW = $clog2(DW + 2);

  logic          busy;
  logic          done;
  mdu_op_t       op;
  logic [CW-1:0] cnt;
  logic [DW-1:0] x;
  logic [DW-1:0] y;
  logic [MB-1:0] rr;
  logic [MB:0]   b;

  // restoring divide step
  logic [MB:0] tr;
  logic [MB:0] diff;
  logic        ge;

  assign tr   = {rr, x[DW-1]};
  assign diff = tr - b;
  assign ge   = (tr >= b);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= (cmd.op == OP_DIV) ? CW'(DW) : CW'(MB + 1);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op <= cmd.op;
      x  <= opa;
      y  <= '0;
      rr <= '0;
      b  <= opb;
    end else if (busy) begin
      if (op == OP_DIV) begin
        rr <= ge ? diff[MB-1:0] : tr[MB-1:0];
        x  <= {x[DW-2:0], ge};
      end else begin
        if (b[0]) y <= y + x;
        x <= {x[DW-2:0], 1'b0};
        b <= {1'b0, b[MB:1]};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign quo      = x;
  assign prod     = y;
  assign rem      = rr;

endmodule
